// File: design/sha512_256_hash_engine_assert.svh
// Assertion macros for the SHA-512/256 hash engine.
`ifndef SHA512_256_HASH_ENGINE_ASSERT_SVH
`define SHA512_256_HASH_ENGINE_ASSERT_SVH

// Check that cond holds whenever trig holds in the same cycle.
`define SHA_ASSERT_SAME(lbl, clk, rst, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("assertion failed");

// Check that cond holds in the cycle after trig.
`define SHA_ASSERT_NEXT(lbl, clk, rst, trig, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("assertion failed");

`endif

// File: design/s512_pkg.sv
// Package: types, constants and round-constant table of the SHA-512/256 engine.
package s512_pkg;

  localparam int BLOCK_WORDS = 16;
  localparam int ROUND_COUNT = 80;
  localparam int LEN_WORD    = 14;

  typedef logic [63:0] word_t;

  typedef struct packed {
    word_t a;
    word_t b;
    word_t c;
    word_t d;
    word_t e;
    word_t f;
    word_t g;
    word_t h;
  } vars_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ABS,
    ST_PAD,
    ST_ZERO,
    ST_LEN,
    ST_ROUND,
    ST_FOLD,
    ST_DONE
  } state_t;

  typedef enum logic [1:0] {
    PH_DATA,
    PH_FILL,
    PH_FINAL
  } phase_t;

  localparam vars_t IV = '{
    a: 64'h22312194fc2bf72c, b: 64'h9f555fa3c84c64c2,
    c: 64'h2393b86b6f53b151, d: 64'h963877195940eabd,
    e: 64'h96283ee2a88effe3, f: 64'hbe5e1e2553863992,
    g: 64'h2b0199fc2c85b8aa, h: 64'h0eb72ddc81c52ca2
  };

  localparam word_t PAD_WORD = 64'h8000000000000000;

  function automatic word_t round_k(input logic [6:0] idx);
    word_t k;
    unique case (idx)
      7'd0:  k = 64'h428a2f98d728ae22;  7'd1:  k = 64'h7137449123ef65cd;
      7'd2:  k = 64'hb5c0fbcfec4d3b2f;  7'd3:  k = 64'he9b5dba58189dbbc;
      7'd4:  k = 64'h3956c25bf348b538;  7'd5:  k = 64'h59f111f1b605d019;
      7'd6:  k = 64'h923f82a4af194f9b;  7'd7:  k = 64'hab1c5ed5da6d8118;
      7'd8:  k = 64'hd807aa98a3030242;  7'd9:  k = 64'h12835b0145706fbe;
      7'd10: k = 64'h243185be4ee4b28c;  7'd11: k = 64'h550c7dc3d5ffb4e2;
      7'd12: k = 64'h72be5d74f27b896f;  7'd13: k = 64'h80deb1fe3b1696b1;
      7'd14: k = 64'h9bdc06a725c71235;  7'd15: k = 64'hc19bf174cf692694;
      7'd16: k = 64'he49b69c19ef14ad2;  7'd17: k = 64'hefbe4786384f25e3;
      7'd18: k = 64'h0fc19dc68b8cd5b5;  7'd19: k = 64'h240ca1cc77ac9c65;
      7'd20: k = 64'h2de92c6f592b0275;  7'd21: k = 64'h4a7484aa6ea6e483;
      7'd22: k = 64'h5cb0a9dcbd41fbd4;  7'd23: k = 64'h76f988da831153b5;
      7'd24: k = 64'h983e5152ee66dfab;  7'd25: k = 64'ha831c66d2db43210;
      7'd26: k = 64'hb00327c898fb213f;  7'd27: k = 64'hbf597fc7beef0ee4;
      7'd28: k = 64'hc6e00bf33da88fc2;  7'd29: k = 64'hd5a79147930aa725;
      7'd30: k = 64'h06ca6351e003826f;  7'd31: k = 64'h142929670a0e6e70;
      7'd32: k = 64'h27b70a8546d22ffc;  7'd33: k = 64'h2e1b21385c26c926;
      7'd34: k = 64'h4d2c6dfc5ac42aed;  7'd35: k = 64'h53380d139d95b3df;
      7'd36: k = 64'h650a73548baf63de;  7'd37: k = 64'h766a0abb3c77b2a8;
      7'd38: k = 64'h81c2c92e47edaee6;  7'd39: k = 64'h92722c851482353b;
      7'd40: k = 64'ha2bfe8a14cf10364;  7'd41: k = 64'ha81a664bbc423001;
      7'd42: k = 64'hc24b8b70d0f89791;  7'd43: k = 64'hc76c51a30654be30;
      7'd44: k = 64'hd192e819d6ef5218;  7'd45: k = 64'hd69906245565a910;
      7'd46: k = 64'hf40e35855771202a;  7'd47: k = 64'h106aa07032bbd1b8;
      7'd48: k = 64'h19a4c116b8d2d0c8;  7'd49: k = 64'h1e376c085141ab53;
      7'd50: k = 64'h2748774cdf8eeb99;  7'd51: k = 64'h34b0bcb5e19b48a8;
      7'd52: k = 64'h391c0cb3c5c95a63;  7'd53: k = 64'h4ed8aa4ae3418acb;
      7'd54: k = 64'h5b9cca4f7763e373;  7'd55: k = 64'h682e6ff3d6b2b8a3;
      7'd56: k = 64'h748f82ee5defb2fc;  7'd57: k = 64'h78a5636f43172f60;
      7'd58: k = 64'h84c87814a1f0ab72;  7'd59: k = 64'h8cc702081a6439ec;
      7'd60: k = 64'h90befffa23631e28;  7'd61: k = 64'ha4506cebde82bde9;
      7'd62: k = 64'hbef9a3f7b2c67915;  7'd63: k = 64'hc67178f2e372532b;
      7'd64: k = 64'hca273eceea26619c;  7'd65: k = 64'hd186b8c721c0c207;
      7'd66: k = 64'heada7dd6cde0eb1e;  7'd67: k = 64'hf57d4f7fee6ed178;
      7'd68: k = 64'h06f067aa72176fba;  7'd69: k = 64'h0a637dc5a2c898a6;
      7'd70: k = 64'h113f9804bef90dae;  7'd71: k = 64'h1b710b35131c471b;
      7'd72: k = 64'h28db77f523047d84;  7'd73: k = 64'h32caab7b40c72493;
      7'd74: k = 64'h3c9ebe0a15c9bebc;  7'd75: k = 64'h431d67c49c100d4c;
      7'd76: k = 64'h4cc5d4becb3e42b6;  7'd77: k = 64'h597f299cfc657e2a;
      7'd78: k = 64'h5fcb6fab3ad6faec;  7'd79: k = 64'h6c44198c4a475817;
      default: k = '0;
    endcase
    return k;
  endfunction

endpackage

// File: design/s512_round.sv
// One SHA-512 round with message schedule expansion, reused for all 80 rounds.
module s512_round (
  input  s512_pkg::vars_t v,
  input  logic [6:0]      rnd,
  input  s512_pkg::word_t w0,
  input  s512_pkg::word_t w1,
  input  s512_pkg::word_t w9,
  input  s512_pkg::word_t w14,
  output s512_pkg::vars_t v_next,
  output s512_pkg::word_t w_cur
);

  s512_pkg::word_t sig0, sig1, bs0, bs1, ch, maj, t1, t2;

  assign sig0  = {w1[0], w1[63:1]} ^ {w1[7:0], w1[63:8]} ^ (w1 >> 7);
  assign sig1  = {w14[18:0], w14[63:19]} ^ {w14[60:0], w14[63:61]} ^ (w14 >> 6);
  // first 16 rounds take the block word as is
  assign w_cur = (rnd < 7'(s512_pkg::BLOCK_WORDS)) ? w0 : (sig1 + w9 + sig0 + w0);

  assign bs1 = {v.e[13:0], v.e[63:14]} ^ {v.e[17:0], v.e[63:18]} ^ {v.e[40:0], v.e[63:41]};
  assign bs0 = {v.a[27:0], v.a[63:28]} ^ {v.a[33:0], v.a[63:34]} ^ {v.a[38:0], v.a[63:39]};
  assign ch  = (v.e & v.f) ^ (~v.e & v.g);
  assign maj = (v.a & v.b) ^ (v.a & v.c) ^ (v.b & v.c);
  assign t1  = v.h + bs1 + ch + s512_pkg::round_k(rnd) + w_cur;
  assign t2  = bs0 + maj;

  always_comb begin
    v_next   = v;
    v_next.h = v.g;
    v_next.g = v.f;
    v_next.f = v.e;
    v_next.e = v.d + t1;
    v_next.d = v.c;
    v_next.c = v.b;
    v_next.b = v.a;
    v_next.a = t1 + t2;
  end

endmodule

// File: design/sha512_256_hash_engine.sv
// Top level: SHA-512/256 engine with input staging, padding sequencer and round unit.
// A word that does not fill a block is only staged and merged; a word that completes a
// block adds 80 rounds on the shared round unit and the fold. A last word adds
// padding, one or two compressions and, in double mode, another padded compression.
// One item at a time: a new word is taken only while the engine is idle.
// Reset (rst, synchronous): chain value to the initial hash, counts cleared, idle.
module sha512_256_hash_engine (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] msg_word,
  input  logic [3:0]  valid_bytes,
  input  logic        last_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] digest_0,
  output logic [63:0] digest_1,
  output logic [63:0] digest_2,
  output logic [63:0] digest_3,
  input  logic        cfg_we,
  input  logic        cfg_wdata
);

  `include "sha512_256_hash_engine_assert.svh"

  s512_pkg::state_t state, state_next;
  s512_pkg::phase_t phase;

  // block buffer doubles as the schedule shift line during rounds
  s512_pkg::word_t blk [s512_pkg::BLOCK_WORDS];
  s512_pkg::vars_t chain, wv, wv_next;
  s512_pkg::word_t w_cur;

  logic        double_hash;
  logic        second;
  logic [63:0] total;
  logic [4:0]  wcnt;
  logic [6:0]  rnd;
  logic [63:0] part;
  logic [2:0]  part_cnt;
  logic [63:0] word_r;
  logic [3:0]  cnt_r;
  logic        last_r;

  // staging: merge the held partial word with the new valid bytes
  logic [63:0]  mask;
  logic [63:0]  part_keep;
  logic [127:0] merged;
  logic [3:0]   sum;
  logic         push;
  logic         start_comp;
  logic         emit;

  assign mask      = ~(64'hffff_ffff_ffff_ffff >> {cnt_r, 3'b000});
  // keep only the bytes that are still held, drop anything stale below them
  assign part_keep = part & ~(64'hffff_ffff_ffff_ffff >> {part_cnt, 3'b000});
  assign merged    = {part_keep, 64'h0} | ({word_r & mask, 64'h0} >> {part_cnt, 3'b000});
  assign sum       = {1'b0, part_cnt} + cnt_r;
  assign push      = sum[3];

  // hand the final digest to the output register
  assign emit = (state == s512_pkg::ST_DONE) && !(double_hash && !second) &&
                (!out_valid || out_ready);

  s512_round u_round (
    .v      (wv),
    .rnd    (rnd),
    .w0     (blk[0]),
    .w1     (blk[1]),
    .w9     (blk[9]),
    .w14    (blk[14]),
    .v_next (wv_next),
    .w_cur  (w_cur)
  );

  assign in_ready = (state == s512_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= s512_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and compression start
  always_comb begin
    state_next = state;
    start_comp = 1'b0;
    unique case (state)
      s512_pkg::ST_IDLE: begin
        if (in_valid) state_next = s512_pkg::ST_ABS;
      end
      s512_pkg::ST_ABS: begin
        if (push && wcnt == 5'(s512_pkg::BLOCK_WORDS - 1)) begin
          start_comp = 1'b1;
          state_next = s512_pkg::ST_ROUND;
        end else if (last_r) begin
          state_next = s512_pkg::ST_PAD;
        end else begin
          state_next = s512_pkg::ST_IDLE;
        end
      end
      s512_pkg::ST_PAD: begin
        if (wcnt == 5'(s512_pkg::BLOCK_WORDS - 1)) begin
          start_comp = 1'b1;
          state_next = s512_pkg::ST_ROUND;
        end else begin
          state_next = s512_pkg::ST_ZERO;
        end
      end
      s512_pkg::ST_ZERO: begin
        // pad byte landed in the length word: zero the last word and compress first
        if (wcnt == 5'(s512_pkg::BLOCK_WORDS - 1)) begin
          start_comp = 1'b1;
          state_next = s512_pkg::ST_ROUND;
        end else if (wcnt == 5'(s512_pkg::LEN_WORD)) begin
          state_next = s512_pkg::ST_LEN;
        end
      end
      s512_pkg::ST_LEN: begin
        start_comp = 1'b1;
        state_next = s512_pkg::ST_ROUND;
      end
      s512_pkg::ST_ROUND: begin
        if (rnd == 7'(s512_pkg::ROUND_COUNT - 1)) state_next = s512_pkg::ST_FOLD;
      end
      s512_pkg::ST_FOLD: begin
        unique case (phase)
          s512_pkg::PH_DATA:  state_next = last_r ? s512_pkg::ST_PAD : s512_pkg::ST_IDLE;
          s512_pkg::PH_FILL:  state_next = s512_pkg::ST_ZERO;
          s512_pkg::PH_FINAL: state_next = s512_pkg::ST_DONE;
          default:            state_next = s512_pkg::ST_IDLE;
        endcase
      end
      s512_pkg::ST_DONE: begin
        if (double_hash && !second) begin
          state_next = s512_pkg::ST_PAD;
        end else if (!out_valid || out_ready) begin
          state_next = s512_pkg::ST_IDLE;
        end
      end
      default: state_next = s512_pkg::ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      double_hash <= 1'b0;
      second      <= 1'b0;
      total       <= '0;
      wcnt        <= '0;
      rnd         <= '0;
      part_cnt    <= '0;
      phase       <= s512_pkg::PH_DATA;
      chain       <= s512_pkg::IV;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_we) double_hash <= cfg_wdata;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        s512_pkg::ST_IDLE: begin
          if (in_valid) begin
            // more than eight counts as eight
            total <= total + ((valid_bytes > 4'd8) ? 64'd8 : 64'(valid_bytes));
          end
        end
        s512_pkg::ST_ABS: begin
          part_cnt <= push ? 3'(sum - 4'd8) : sum[2:0];
          if (start_comp) begin
            wcnt <= '0;
          end else if (push) begin
            wcnt <= wcnt + 5'd1;
          end
          phase <= s512_pkg::PH_DATA;
        end
        s512_pkg::ST_PAD: begin
          part_cnt <= '0;
          wcnt     <= start_comp ? 5'd0 : wcnt + 5'd1;
          phase    <= s512_pkg::PH_FILL;
        end
        s512_pkg::ST_ZERO: begin
          if (start_comp) begin
            wcnt <= '0;
          end else if (wcnt != 5'(s512_pkg::LEN_WORD)) begin
            wcnt <= wcnt + 5'd1;
          end
        end
        s512_pkg::ST_LEN: begin
          wcnt  <= '0;
          phase <= s512_pkg::PH_FINAL;
        end
        s512_pkg::ST_ROUND: begin
          rnd <= rnd + 7'd1;
        end
        s512_pkg::ST_FOLD: begin
          rnd   <= '0;
          chain <= '{a: chain.a + wv.a, b: chain.b + wv.b, c: chain.c + wv.c,
                     d: chain.d + wv.d, e: chain.e + wv.e, f: chain.f + wv.f,
                     g: chain.g + wv.g, h: chain.h + wv.h};
        end
        s512_pkg::ST_DONE: begin
          if (double_hash && !second) begin
            // rehash the 32-byte digest: four full words already in place
            second   <= 1'b1;
            chain    <= s512_pkg::IV;
            total    <= 64'd32;
            wcnt     <= 5'd4;
            part_cnt <= '0;
          end else if (emit) begin
            second    <= 1'b0;
            chain     <= s512_pkg::IV;
            total     <= '0;
            wcnt      <= '0;
            part_cnt  <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == s512_pkg::ST_IDLE && in_valid) begin
      word_r <= msg_word;
      cnt_r  <= (valid_bytes > 4'd8) ? 4'd8 : valid_bytes;
      last_r <= last_word;
    end
    if (state == s512_pkg::ST_ABS) begin
      part <= push ? merged[63:0] : merged[127:64];
    end
    if (start_comp) begin
      wv <= chain;
    end else if (state == s512_pkg::ST_ROUND) begin
      wv <= wv_next;
    end
    if (emit) begin
      digest_0 <= chain.a;
      digest_1 <= chain.b;
      digest_2 <= chain.c;
      digest_3 <= chain.d;
    end
  end

  // block buffer: indexed writes while filling, shift during rounds
  always_ff @(posedge clk) begin
    unique case (state)
      s512_pkg::ST_ABS: begin
        if (push) blk[wcnt[3:0]] <= merged[127:64];
      end
      s512_pkg::ST_PAD: begin
        blk[wcnt[3:0]] <= part_keep | (s512_pkg::PAD_WORD >> {part_cnt, 3'b000});
      end
      s512_pkg::ST_ZERO: begin
        if (wcnt != 5'(s512_pkg::LEN_WORD)) blk[wcnt[3:0]] <= '0;
      end
      s512_pkg::ST_LEN: begin
        blk[s512_pkg::LEN_WORD]     <= {61'h0, total[63:61]};
        blk[s512_pkg::LEN_WORD + 1] <= {total[60:0], 3'b000};
      end
      s512_pkg::ST_ROUND: begin
        for (int i = 0; i < s512_pkg::BLOCK_WORDS - 1; i++) begin
          blk[i] <= blk[i + 1];
        end
        blk[s512_pkg::BLOCK_WORDS - 1] <= w_cur;
      end
      s512_pkg::ST_DONE: begin
        if (double_hash && !second) begin
          blk[0] <= chain.a;
          blk[1] <= chain.b;
          blk[2] <= chain.c;
          blk[3] <= chain.d;
        end
      end
      default: ;
    endcase
  end

  // busy right after an item is taken
  `SHA_ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  // round counter never runs past the last round
  `SHA_ASSERT_SAME(a_rnd_range, clk, rst, state == s512_pkg::ST_ROUND,
                   rnd < 7'(s512_pkg::ROUND_COUNT))
  // word count stays inside the block
  `SHA_ASSERT_SAME(a_wcnt_range, clk, rst, 1'b1, wcnt < 5'(s512_pkg::BLOCK_WORDS))

endmodule
